### hw/rtl/rcsd_pkg.sv
// Shared constants and types for the ring code sector decoder.
`timescale 1ns / 1ps
package rcsd_pkg;

  localparam int SECTOR_COUNT = 13;

  localparam int SMP_W    = 8;
  localparam int REQ_W    = 4;
  localparam int CODE_W   = 13;
  localparam int ROT_W    = 4;
  localparam int SCORE_W  = 15;
  localparam int GAIN_W   = 11;
  localparam int CFG_IDX_W = 2;

  localparam int IDX_W  = $clog2(SECTOR_COUNT);
  localparam int ONES_W = $clog2(SECTOR_COUNT + 1);
  localparam int CMP_W  = (ONES_W > REQ_W) ? ONES_W : REQ_W;
  localparam int TURN_W = $clog2(SECTOR_COUNT);

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_CUT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_CUT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_ONES = 2'd3;

  localparam logic [SMP_W-1:0] WHITE_CUT_RST     = 8'd53;
  localparam logic [SMP_W-1:0] BLACK_CUT_RST     = 8'd203;
  localparam logic [SMP_W-1:0] BIT_THRESHOLD_RST = 8'd128;
  localparam logic [REQ_W-1:0] REQUIRED_ONES_RST = 4'd5;

  typedef struct packed {
    logic [SMP_W-1:0] white_cut;
    logic [SMP_W-1:0] black_cut;
    logic [SMP_W-1:0] bit_threshold;
    logic [REQ_W-1:0] required_ones;
  } cfg_t;

  typedef struct packed {
    logic [SMP_W-1:0] ring1;
    logic [SMP_W-1:0] ring2;
    logic [SMP_W-1:0] ring3;
    logic [SMP_W-1:0] ring4;
    logic [SMP_W-1:0] ring5;
    logic [SMP_W-1:0] ring6;
    logic [SMP_W-1:0] data;
  } sample_t;

  // one finished read, handed from the accumulator to the rotation search
  typedef struct packed {
    logic                    found;
    logic [SECTOR_COUNT-1:0] word;
    logic [SCORE_W-1:0]      score;
  } read_t;

endpackage

### hw/rtl/rcsd_accum.sv
// Per-sector ring checks, score and bit accumulation; holds one finished read.
`timescale 1ns / 1ps
module rcsd_accum (
  input  logic             clk,
  input  logic             rst_n,
  input  rcsd_pkg::cfg_t    cfg,
  input  logic             smp_valid,
  input  rcsd_pkg::sample_t smp,
  output logic             smp_take,
  output logic             res_valid,
  output rcsd_pkg::read_t   res,
  input  logic             res_take
);
  import rcsd_pkg::*;

  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    rej_r, rej_nxt;
  logic [SCORE_W-1:0]      score_r, score_nxt;
  logic [SECTOR_COUNT-1:0] word_r, word_nxt;
  logic [ONES_W-1:0]       ones_r, ones_nxt;
  logic                    res_valid_r;
  read_t                   res_r;

  logic               last;
  logic               res_free;
  logic               bad;
  logic               bit_one;
  logic [SMP_W-1:0]   conf;
  logic [SMP_W:0]     data_x2;
  logic [GAIN_W-1:0]  gain;
  logic [SCORE_W:0]   sum;

  assign last     = (idx_r == IDX_W'(SECTOR_COUNT - 1));
  assign res_free = !res_valid_r || res_take;
  assign smp_take = smp_valid && (!last || res_free);

  always_comb begin
    bad = (smp.ring1 <= cfg.white_cut) || (smp.ring3 <= cfg.white_cut) ||
          (smp.ring4 <= cfg.white_cut) || (smp.ring6 <= cfg.white_cut) ||
          (smp.ring2 >  cfg.black_cut) || (smp.ring5 >  cfg.black_cut);
    bit_one = smp.data > cfg.bit_threshold;
    // |2d - 255|: 2d >= 255 exactly when the top bit of d is set
    data_x2 = {smp.data, 1'b0};
    if (smp.data[SMP_W-1]) begin
      conf = SMP_W'(data_x2 - 9'd255);
    end else begin
      conf = SMP_W'(9'd255 - data_x2);
    end
    gain = GAIN_W'(smp.ring1) + GAIN_W'(smp.ring3) + GAIN_W'(smp.ring4) +
           GAIN_W'(smp.ring6) + GAIN_W'(8'd255 - smp.ring2) +
           GAIN_W'(8'd255 - smp.ring5) + GAIN_W'(conf);
    sum = (SCORE_W + 1)'(score_r) + (SCORE_W + 1)'(gain);
    rej_nxt   = rej_r || bad;
    score_nxt = sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];
    word_nxt  = {word_r[SECTOR_COUNT-2:0], bit_one};
    ones_nxt  = ones_r + ONES_W'(bit_one);
    idx_nxt   = idx_r + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      rej_r       <= 1'b0;
      score_r     <= '0;
      word_r      <= '0;
      ones_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (res_take) begin
        res_valid_r <= 1'b0;
      end
      if (smp_take) begin
        if (last) begin
          idx_r       <= '0;
          rej_r       <= 1'b0;
          score_r     <= '0;
          word_r      <= '0;
          ones_r      <= '0;
          res_valid_r <= 1'b1;
        end else begin
          idx_r   <= idx_nxt;
          rej_r   <= rej_nxt;
          score_r <= score_nxt;
          word_r  <= word_nxt;
          ones_r  <= ones_nxt;
        end
      end
    end
  end

  // finished read payload
  always_ff @(posedge clk) begin
    if (smp_take && last) begin
      res_r.found <= !rej_nxt && (CMP_W'(ones_nxt) == CMP_W'(cfg.required_ones));
      res_r.word  <= word_nxt;
      res_r.score <= score_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

### hw/rtl/rcsd_rotmin.sv
// Lowest-rotation search over a finished code word and the result register.
`timescale 1ns / 1ps
module rcsd_rotmin (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_valid,
  input  rcsd_pkg::read_t              rd,
  output logic                         rd_take,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_found,
  output logic [rcsd_pkg::CODE_W-1:0]  out_code_word,
  output logic [rcsd_pkg::ROT_W-1:0]   out_rotation,
  output logic [rcsd_pkg::SCORE_W-1:0] out_confidence
);
  import rcsd_pkg::*;

  localparam int LV = $clog2(SECTOR_COUNT);
  localparam int NL = 1 << LV;

  logic [2*SECTOR_COUNT-1:0] dbl;
  logic [SECTOR_COUNT-1:0]   tw [LV+1][NL];
  logic [TURN_W-1:0]         tt [LV+1][NL];
  logic                      tv [LV+1][NL];
  logic                      pick;
  logic                      out_adv;

  logic                    out_valid_r;
  logic                    found_r;
  logic [CODE_W-1:0]       code_r;
  logic [ROT_W-1:0]        rot_r;
  logic [SCORE_W-1:0]      conf_r;

  // rotation tree: leaves are the left rotations, ties keep the lower count
  always_comb begin
    dbl  = {rd.word, rd.word};
    pick = 1'b0;
    for (int l = 0; l <= LV; l++) begin
      for (int j = 0; j < NL; j++) begin
        tw[l][j] = '0;
        tt[l][j] = '0;
        tv[l][j] = 1'b0;
      end
    end
    for (int i = 0; i < SECTOR_COUNT; i++) begin
      tw[0][i] = dbl[(2*SECTOR_COUNT-1-i) -: SECTOR_COUNT];
      tt[0][i] = TURN_W'(i);
      tv[0][i] = 1'b1;
    end
    for (int l = 0; l < LV; l++) begin
      for (int j = 0; j < NL / 2; j++) begin
        if (j < (NL >> (l + 1))) begin
          pick = tv[l][2*j+1] && (!tv[l][2*j] || (tw[l][2*j+1] < tw[l][2*j]));
          tw[l+1][j] = pick ? tw[l][2*j+1] : tw[l][2*j];
          tt[l+1][j] = pick ? tt[l][2*j+1] : tt[l][2*j];
          tv[l+1][j] = tv[l][2*j] || tv[l][2*j+1];
        end
      end
    end
  end

  assign out_adv = !out_valid_r || out_ready;
  assign rd_take = rd_valid && out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_take) begin
      found_r <= rd.found;
      code_r  <= rd.found ? CODE_W'(tw[LV][0]) : '0;
      rot_r   <= rd.found ? ROT_W'(tt[LV][0]) : '0;
      conf_r  <= rd.found ? rd.score : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = found_r;
  assign out_code_word  = code_r;
  assign out_rotation   = rot_r;
  assign out_confidence = conf_r;

endmodule

### hw/rtl/ring_code_sector_decoder_unit.sv
// Top level of the ring code sector decoder: config registers, input register, stages.
`timescale 1ns / 1ps
// Ring code sector decoder.
// in_*  : one item per sector of the fiducial, six ring samples and one data
//         sample, valid/ready. After every SECTOR_COUNT items one result
//         item leaves on out_*: found, lowest rotation of the code word,
//         rotation count and summed confidence (zeros when not found).
// cfg_* : write port, cfg_we with cfg_index selecting white cut, black cut,
//         bit threshold or required ones count; no wait states, no read.
// Pipeline: input register -> sector accumulator (checks, score, bit
//   shift; holds the finished read) -> rotation tree and result register.
// Throughput: one item per cycle, sustained while out_ready stays high (see Stall).
// Result path: the edge that takes the last sector fills the accumulator's read
//   register; the result register on out_* loads from it when out_ready allows.
// Reset (rst_n low, synchronous): accumulators and valid flags clear, the
//   config registers return to 53, 203, 128 and 5.
// Stall: when out_ready is low the result register holds and one more
//   finished read waits behind it; the accumulator still takes sectors up to
//   the last sector of the following read, which then waits in the input
//   register, and in_ready drops.
module ring_code_sector_decoder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rcsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcsd_pkg::SMP_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rcsd_pkg::SMP_W-1:0]     in_ring1_level,
  input  logic [rcsd_pkg::SMP_W-1:0]     in_ring2_level,
  input  logic [rcsd_pkg::SMP_W-1:0]     in_ring3_level,
  input  logic [rcsd_pkg::SMP_W-1:0]     in_ring4_level,
  input  logic [rcsd_pkg::SMP_W-1:0]     in_ring5_level,
  input  logic [rcsd_pkg::SMP_W-1:0]     in_ring6_level,
  input  logic [rcsd_pkg::SMP_W-1:0]     in_data_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_found,
  output logic [rcsd_pkg::CODE_W-1:0]    out_code_word,
  output logic [rcsd_pkg::ROT_W-1:0]     out_rotation,
  output logic [rcsd_pkg::SCORE_W-1:0]   out_confidence
);
  import rcsd_pkg::*;

  cfg_t    cfg_r;
  logic    smp_valid_r;
  sample_t smp_r;
  logic    smp_take;
  logic    rd_valid;
  read_t   rd;
  logic    rd_take;

  // config registers; unknown indexes cannot occur with a two-bit index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.white_cut     <= WHITE_CUT_RST;
      cfg_r.black_cut     <= BLACK_CUT_RST;
      cfg_r.bit_threshold <= BIT_THRESHOLD_RST;
      cfg_r.required_ones <= REQUIRED_ONES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WHITE_CUT:     cfg_r.white_cut     <= cfg_wdata;
        REG_BLACK_CUT:     cfg_r.black_cut     <= cfg_wdata;
        REG_BIT_THRESHOLD: cfg_r.bit_threshold <= cfg_wdata;
        REG_REQUIRED_ONES: cfg_r.required_ones <= cfg_wdata[REQ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register: refills in the cycle its item moves on
  assign in_ready = !smp_valid_r || smp_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
    end else if (in_ready) begin
      smp_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_r.ring1 <= in_ring1_level;
      smp_r.ring2 <= in_ring2_level;
      smp_r.ring3 <= in_ring3_level;
      smp_r.ring4 <= in_ring4_level;
      smp_r.ring5 <= in_ring5_level;
      smp_r.ring6 <= in_ring6_level;
      smp_r.data  <= in_data_level;
    end
  end

  rcsd_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .smp_valid (smp_valid_r),
    .smp       (smp_r),
    .smp_take  (smp_take),
    .res_valid (rd_valid),
    .res       (rd),
    .res_take  (rd_take)
  );

  rcsd_rotmin u_rotmin (
    .clk            (clk),
    .rst_n          (rst_n),
    .rd_valid       (rd_valid),
    .rd             (rd),
    .rd_take        (rd_take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_code_word  (out_code_word),
    .out_rotation   (out_rotation),
    .out_confidence (out_confidence)
  );

endmodule
